>>> src/pepu_pkg.sv
// Shared types, widths and saturation helper for the proximity embedding pair update block.
// No dependencies; imported by every module of the block except pepu_ram.
package pepu_pkg;

	localparam int DEF_POINT_COUNT     = 256;
	localparam int DEF_MAX_INPUT_DIMS  = 16;
	localparam int DEF_MAX_OUTPUT_DIMS = 4;

	localparam int COORD_W    = 32;
	localparam int DIST_W     = 31;
	localparam int GAIN_W     = 17;
	localparam int PT_W       = 8;
	localparam int DIM_W      = 4;
	localparam int ACT_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;
	localparam int NIN_W      = 5;
	localparam int NOUT_W     = 3;
	localparam int SQ_W       = 64;
	localparam int ROOT_W     = 32;
	localparam int DVD_W      = 63;
	localparam int DVS_W      = 32;
	localparam int MOVE_W     = 34;
	localparam int SUM_W      = 36;

	localparam logic [DIST_W-1:0] CUT_RESET  = '1;
	localparam logic [NIN_W-1:0]  NIN_RESET  = NIN_W'(2);
	localparam logic [NOUT_W-1:0] NOUT_RESET = NOUT_W'(2);

	typedef enum logic [ACT_W-1:0] {
		ACT_WR_ORIG = 2'd0,
		ACT_WR_EMB  = 2'd1,
		ACT_RD_EMB  = 2'd2,
		ACT_PAIR    = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CUT      = 2'd0,
		REG_IN_DIMS  = 2'd1,
		REG_OUT_DIMS = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic capture;
		logic mem_orig;
		logic rd_a;
		logic rd_b;
		logic rd_item;
		logic lat_a;
		logic lat_b;
		logic sq;
		logic acc_clr;
		logic acc;
		logic sqrt_start;
		logic dist_store;
		logic div_start;
		logic mul;
		logic mag;
		logic wr_a;
		logic wr_b;
		logic wr_item;
		logic out_load;
		logic k_clr;
		logic k_inc;
	} pepu_cmd_t;

	typedef struct packed {
		action_t act;
		logic    k_last;
		logic    sqrt_done;
		logic    div_done;
		logic    skip;
	} pepu_stat_t;

	function automatic logic [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(32'sh7FFFFFFF);
		lo = -SUM_W'(33'sh080000000);
		if (s > hi)
			sat32 = 32'h7FFFFFFF;
		else if (s < lo)
			sat32 = 32'h80000000;
		else
			sat32 = s[COORD_W-1:0];
	endfunction

endpackage

>>> src/pepu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module pepu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

>>> src/pepu_sqrt.sv
// Iterative floor square root, one result bit per cycle.
// Depends on pepu_pkg.
module pepu_sqrt
	import pepu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int CW = $clog2(ROOT_W);

	logic              run_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [SQ_W-1:0]   v_q;
	logic [ROOT_W:0]   rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W+2:0] rem_sh;
	logic [ROOT_W+2:0] trial;
	logic              fits;

	assign rem_sh = {rem_q, v_q[SQ_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CW'(ROOT_W - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(ROOT_W - 1))
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			v_q <= {v_q[SQ_W-3:0], 2'b00};
			// remainder stays below 2*root+1, so its top bits are always zero
			rem_q  <= fits ? (ROOT_W+1)'(rem_sh - trial) : rem_sh[ROOT_W:0];
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> src/pepu_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pepu_pkg.
module pepu_div
	import pepu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CW = $clog2(DVD_W);

	logic             run_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DVD_W-1:0] q_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W:0]   rem_sh;
	logic             fits;

	assign rem_sh = {rem_q, q_q[DVD_W-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CW'(DVD_W - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DVD_W - 1))
					run_q <= 1'b0;
			end
		end
	end

	// dividend bits shift out of q_q's top as quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
			q_q   <= {q_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = q_q;

endmodule

>>> src/pepu_dpath.sv
// Datapath: coordinate memories, distance accumulation, square root, step division,
// per-dimension move and result registers. Depends on pepu_pkg, pepu_ram, pepu_sqrt, pepu_div.
module pepu_dpath
	import pepu_pkg::*;
#(
	parameter int POINT_COUNT     = DEF_POINT_COUNT,
	parameter int MAX_INPUT_DIMS  = DEF_MAX_INPUT_DIMS,
	parameter int MAX_OUTPUT_DIMS = DEF_MAX_OUTPUT_DIMS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pepu_cmd_t                cmd,
	output pepu_stat_t               stat,
	input  logic [ACT_W-1:0]         action,
	input  logic [PT_W-1:0]          first_point,
	input  logic [PT_W-1:0]          second_point,
	input  logic [DIM_W-1:0]         dim_index,
	input  logic signed [COORD_W-1:0] write_value,
	input  logic [GAIN_W-1:0]        step_gain,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	output logic signed [COORD_W-1:0] read_value,
	output logic                     pair_moved,
	output logic [DIST_W-1:0]        embed_distance,
	output logic [DIST_W-1:0]        orig_distance
);

	localparam int PW   = $clog2(POINT_COUNT);
	localparam int OAW  = $clog2(POINT_COUNT * MAX_INPUT_DIMS);
	localparam int EAW  = $clog2(POINT_COUNT * MAX_OUTPUT_DIMS);
	localparam int KMAX = (MAX_INPUT_DIMS > MAX_OUTPUT_DIMS) ? MAX_INPUT_DIMS : MAX_OUTPUT_DIMS;
	localparam int KW   = $clog2(KMAX + 1);

	// request fields
	action_t            act_q;
	logic [PW-1:0]      pa_q;
	logic [PW-1:0]      pb_q;
	logic [DIM_W-1:0]   dim_q;
	logic [COORD_W-1:0] wval_q;
	logic [GAIN_W-1:0]  gain_q;

	// configuration
	logic [DIST_W-1:0]  cut_q;
	logic [NIN_W-1:0]   nin_cfg_q;
	logic [NOUT_W-1:0]  nout_cfg_q;

	logic [KW-1:0]      k_q;
	logic [KW-1:0]      nin;
	logic [KW-1:0]      nout;
	logic [KW-1:0]      n_cur;

	logic [COORD_W-1:0] xa_q;
	logic [COORD_W-1:0] xb_q;
	logic [ROOT_W-1:0]  dm_q;
	logic               dneg_q;
	logic [SQ_W-1:0]    sq_q;
	logic [SQ_W-1:0]    acc_q;
	logic               numneg_q;
	logic [SQ_W-1:0]    plo_q;
	logic [SQ_W-2:0]    phi_q;
	logic [MOVE_W-1:0]  m_q;

	logic [COORD_W-1:0] rd_value_q;
	logic               moved_q;
	logic [DIST_W-1:0]  emb_q;
	logic [DIST_W-1:0]  orig_q;

	logic [COORD_W-1:0] o_rdata;
	logic [COORD_W-1:0] e_rdata;
	logic [COORD_W-1:0] rdata;
	logic               o_we;
	logic               e_we;
	logic               o_re;
	logic               e_re;
	logic [OAW-1:0]     o_waddr;
	logic [OAW-1:0]     o_raddr;
	logic [EAW-1:0]     e_waddr;
	logic [EAW-1:0]     e_raddr;
	logic [COORD_W-1:0] e_wdata;
	logic [PW-1:0]      rpt;
	logic [KW-1:0]      rk;

	logic               sqrt_done;
	logic [ROOT_W-1:0]  root;
	logic [DIST_W-1:0]  root_sat;
	logic               div_done;
	logic [DVD_W-1:0]   quot;

	logic signed [COORD_W:0]  diff;
	logic [COORD_W:0]         diff_mag;
	logic [SQ_W:0]            acc_sum;
	logic [DIST_W-1:0]        nmag;
	logic [DVD_W-1:0]         dividend;
	logic [DVS_W-1:0]         divisor;
	logic [SQ_W-1:0]          move_sum;
	logic signed [SUM_W-1:0]  mv;
	logic [COORD_W-1:0]       na;
	logic [COORD_W-1:0]       nb;
	logic                     dim_ok_in;
	logic                     dim_ok_out;

	always_comb begin
		if (nin_cfg_q == '0)
			nin = KW'(1);
		else if (32'(nin_cfg_q) > MAX_INPUT_DIMS)
			nin = KW'(MAX_INPUT_DIMS);
		else
			nin = KW'(nin_cfg_q);
		if (nout_cfg_q == '0)
			nout = KW'(1);
		else if (32'(nout_cfg_q) > MAX_OUTPUT_DIMS)
			nout = KW'(MAX_OUTPUT_DIMS);
		else
			nout = KW'(nout_cfg_q);
	end

	assign n_cur      = cmd.mem_orig ? nin : nout;
	assign dim_ok_in  = 32'(dim_q) < MAX_INPUT_DIMS;
	assign dim_ok_out = 32'(dim_q) < MAX_OUTPUT_DIMS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_q      <= CUT_RESET;
			nin_cfg_q  <= NIN_RESET;
			nout_cfg_q <= NOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CUT:      cut_q      <= cfg_data;
				REG_IN_DIMS:  nin_cfg_q  <= cfg_data[NIN_W-1:0];
				REG_OUT_DIMS: nout_cfg_q <= cfg_data[NOUT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.k_clr) begin
			k_q <= '0;
		end else if (cmd.k_inc) begin
			k_q <= k_q + KW'(1);
		end
	end

	// memory addressing
	assign rpt = cmd.rd_b ? pb_q : pa_q;
	assign rk  = cmd.rd_item ? KW'(dim_q) : k_q;

	assign o_raddr = OAW'(32'(rpt) * MAX_INPUT_DIMS + 32'(rk));
	assign e_raddr = EAW'(32'(rpt) * MAX_OUTPUT_DIMS + 32'(rk));
	assign o_re    = (cmd.rd_a || cmd.rd_b) && cmd.mem_orig;
	assign e_re    = ((cmd.rd_a || cmd.rd_b) && !cmd.mem_orig) || cmd.rd_item;

	assign o_we    = cmd.wr_item && (act_q == ACT_WR_ORIG) && dim_ok_in;
	assign o_waddr = OAW'(32'(pa_q) * MAX_INPUT_DIMS + 32'(dim_q));

	assign e_we = cmd.wr_a || cmd.wr_b || (cmd.wr_item && (act_q == ACT_WR_EMB) && dim_ok_out);
	always_comb begin
		if (cmd.wr_a) begin
			e_waddr = EAW'(32'(pa_q) * MAX_OUTPUT_DIMS + 32'(k_q));
			e_wdata = na;
		end else if (cmd.wr_b) begin
			e_waddr = EAW'(32'(pb_q) * MAX_OUTPUT_DIMS + 32'(k_q));
			e_wdata = nb;
		end else begin
			e_waddr = EAW'(32'(pa_q) * MAX_OUTPUT_DIMS + 32'(dim_q));
			e_wdata = wval_q;
		end
	end

	pepu_ram #(
		.WIDTH (COORD_W),
		.DEPTH (POINT_COUNT * MAX_INPUT_DIMS)
	) u_orig_ram (
		.clk   (clk),
		.we    (o_we),
		.waddr (o_waddr),
		.wdata (wval_q),
		.re    (o_re),
		.raddr (o_raddr),
		.rdata (o_rdata)
	);

	pepu_ram #(
		.WIDTH (COORD_W),
		.DEPTH (POINT_COUNT * MAX_OUTPUT_DIMS)
	) u_emb_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.re    (e_re),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	assign rdata = cmd.mem_orig ? o_rdata : e_rdata;

	// difference of the two coordinates, as magnitude and sign
	assign diff     = $signed({xa_q[COORD_W-1], xa_q}) - $signed({rdata[COORD_W-1], rdata});
	assign diff_mag = diff[COORD_W] ? (COORD_W+1)'(-diff) : (COORD_W+1)'(diff);
	assign acc_sum  = {1'b0, acc_q} + {1'b0, sq_q};

	assign root_sat = (root[ROOT_W-1]) ? '1 : root[DIST_W-1:0];

	assign nmag     = (orig_q < emb_q) ? DIST_W'(emb_q - orig_q) : DIST_W'(orig_q - emb_q);
	assign dividend = {48'(gain_q) * 48'(nmag), 15'b0};
	assign divisor  = DVS_W'(emb_q) + DVS_W'(1);

	assign move_sum = SQ_W'(phi_q) + SQ_W'(plo_q[SQ_W-1:COORD_W]);

	assign mv = (dneg_q ^ numneg_q) ? -$signed(SUM_W'(m_q)) : $signed(SUM_W'(m_q));
	assign na = sat32(SUM_W'($signed(xa_q)) + mv);
	assign nb = sat32(SUM_W'($signed(xb_q)) - mv);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q  <= action_t'(action);
			pa_q   <= PW'(32'(first_point) % POINT_COUNT);
			pb_q   <= PW'(32'(second_point) % POINT_COUNT);
			dim_q  <= dim_index;
			wval_q <= write_value;
			gain_q <= step_gain;
		end
		if (cmd.lat_a)
			xa_q <= rdata;
		if (cmd.lat_b) begin
			xb_q   <= rdata;
			dm_q   <= diff_mag[ROOT_W-1:0];
			dneg_q <= diff[COORD_W];
		end
		if (cmd.sq)
			sq_q <= dm_q * dm_q;
		if (cmd.acc_clr)
			acc_q <= '0;
		else if (cmd.acc)
			acc_q <= acc_sum[SQ_W] ? '1 : acc_sum[SQ_W-1:0];
		if (cmd.div_start)
			numneg_q <= orig_q < emb_q;
		if (cmd.mul) begin
			plo_q <= 64'(quot[COORD_W-1:0]) * 64'(dm_q);
			phi_q <= 63'(quot[DVD_W-1:COORD_W]) * 63'(dm_q);
		end
		if (cmd.mag)
			m_q <= (move_sum > SQ_W'(1) << 33) ? MOVE_W'(1) << 33 : move_sum[MOVE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_value_q <= '0;
			moved_q    <= 1'b0;
			emb_q      <= '0;
			orig_q     <= '0;
		end else if (cmd.capture) begin
			rd_value_q <= '0;
			moved_q    <= 1'b0;
			emb_q      <= '0;
			orig_q     <= '0;
		end else begin
			if (cmd.out_load)
				rd_value_q <= dim_ok_out ? e_rdata : '0;
			if (cmd.dist_store) begin
				if (cmd.mem_orig)
					orig_q <= root_sat;
				else
					emb_q <= root_sat;
			end
			if (cmd.wr_a && (na != xa_q))
				moved_q <= 1'b1;
			if (cmd.wr_b && (nb != xb_q))
				moved_q <= 1'b1;
		end
	end

	pepu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (acc_q),
		.done     (sqrt_done),
		.root     (root)
	);

	pepu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quot)
	);

	assign stat.act       = act_q;
	assign stat.k_last    = k_q == (n_cur - KW'(1));
	assign stat.sqrt_done = sqrt_done;
	assign stat.div_done  = div_done;
	assign stat.skip      = (orig_q > cut_q) && (emb_q >= orig_q);

	assign read_value     = rd_value_q;
	assign pair_moved     = moved_q;
	assign embed_distance = emb_q;
	assign orig_distance  = orig_q;

endmodule

>>> src/pepu_ctrl.sv
// Controller state machine sequencing request dispatch, distance walks, root, divide and moves.
// Depends on pepu_pkg.
module pepu_ctrl
	import pepu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  pepu_stat_t stat,
	output pepu_cmd_t  cmd,
	output logic       busy,
	output logic       done
);

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_RD_DATA,
		S_DA, S_DB, S_DC, S_DSQ, S_DACC,
		S_SQRT_GO, S_SQRT_WAIT, S_DECIDE, S_DIV_WAIT,
		S_MA, S_MB, S_MC, S_MP, S_MM, S_WA, S_WB,
		S_DONE
	} state_t;

	state_t state_q;
	logic   phase_q;	// 0: embedding memory, 1: original memory

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (start) state_q <= S_DISP;
				S_DISP: begin
					phase_q <= 1'b0;
					case (stat.act)
						ACT_RD_EMB: state_q <= S_RD_DATA;
						ACT_PAIR:   state_q <= S_DA;
						default:    state_q <= S_DONE;
					endcase
				end
				S_RD_DATA:  state_q <= S_DONE;
				S_DA:       state_q <= S_DB;
				S_DB:       state_q <= S_DC;
				S_DC:       state_q <= S_DSQ;
				S_DSQ:      state_q <= S_DACC;
				S_DACC:     state_q <= stat.k_last ? S_SQRT_GO : S_DA;
				S_SQRT_GO:  state_q <= S_SQRT_WAIT;
				S_SQRT_WAIT: begin
					if (stat.sqrt_done) begin
						phase_q <= 1'b1;
						state_q <= phase_q ? S_DECIDE : S_DA;
					end
				end
				S_DECIDE: begin
					phase_q <= 1'b0;
					state_q <= stat.skip ? S_DONE : S_DIV_WAIT;
				end
				S_DIV_WAIT: if (stat.div_done) state_q <= S_MA;
				S_MA:       state_q <= S_MB;
				S_MB:       state_q <= S_MC;
				S_MC:       state_q <= S_MP;
				S_MP:       state_q <= S_MM;
				S_MM:       state_q <= S_WA;
				S_WA:       state_q <= S_WB;
				S_WB:       state_q <= stat.k_last ? S_DONE : S_MA;
				S_DONE:     state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.mem_orig = phase_q;
		case (state_q)
			S_IDLE: begin
				cmd.capture = start;
				cmd.k_clr   = start;
			end
			S_DISP: begin
				cmd.mem_orig = 1'b0;
				cmd.wr_item  = 1'b1;
				cmd.rd_item  = stat.act == ACT_RD_EMB;
				cmd.acc_clr  = 1'b1;
			end
			S_RD_DATA: cmd.out_load = 1'b1;
			S_DA:      cmd.rd_a = 1'b1;
			S_DB: begin
				cmd.rd_b  = 1'b1;
				cmd.lat_a = 1'b1;
			end
			S_DC:      cmd.lat_b = 1'b1;
			S_DSQ:     cmd.sq = 1'b1;
			S_DACC: begin
				cmd.acc   = 1'b1;
				cmd.k_clr = stat.k_last;
				cmd.k_inc = !stat.k_last;
			end
			S_SQRT_GO: cmd.sqrt_start = 1'b1;
			S_SQRT_WAIT: begin
				cmd.dist_store = stat.sqrt_done;
				cmd.acc_clr    = stat.sqrt_done;
			end
			S_DECIDE:  cmd.div_start = !stat.skip;
			S_MA: begin
				cmd.mem_orig = 1'b0;
				cmd.rd_a     = 1'b1;
			end
			S_MB: begin
				cmd.mem_orig = 1'b0;
				cmd.rd_b     = 1'b1;
				cmd.lat_a    = 1'b1;
			end
			S_MC: begin
				cmd.mem_orig = 1'b0;
				cmd.lat_b    = 1'b1;
			end
			S_MP:      cmd.mul = 1'b1;
			S_MM:      cmd.mag = 1'b1;
			S_WA: begin
				cmd.mem_orig = 1'b0;
				cmd.wr_a     = 1'b1;
			end
			S_WB: begin
				cmd.mem_orig = 1'b0;
				cmd.wr_b     = 1'b1;
				cmd.k_inc    = !stat.k_last;
			end
			default: begin
			end
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;

endmodule

>>> src/proximity_embedding_pair_update.sv
// Top level of the proximity embedding pair update block: controller plus datapath.
// Depends on pepu_pkg, pepu_ctrl, pepu_dpath.
//
//  channel   handshake               payload
//  request   start & !busy           action, first_point, second_point, dim_index,
//                                    write_value, step_gain
//  result    done (one-cycle strobe) read_value, pair_moved, embed_distance, orig_distance
//  config    cfg_valid & cfg_ready   cfg_index, cfg_data
//
// A pair update uses one memory read port per space, a bit-serial square root (run
// twice) and a bit-serial divide. A skipped pair ends after the two roots. Reset clears
// control, configuration and result registers; coordinate memories hold garbage until
// written. Results cannot be stalled; busy holds off the next request until the result
// strobe has been given.
module proximity_embedding_pair_update
	import pepu_pkg::*;
#(
	parameter int POINT_COUNT     = DEF_POINT_COUNT,
	parameter int MAX_INPUT_DIMS  = DEF_MAX_INPUT_DIMS,
	parameter int MAX_OUTPUT_DIMS = DEF_MAX_OUTPUT_DIMS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [ACT_W-1:0]          action,
	input  logic [PT_W-1:0]           first_point,
	input  logic [PT_W-1:0]           second_point,
	input  logic [DIM_W-1:0]          dim_index,
	input  logic signed [COORD_W-1:0] write_value,
	input  logic [GAIN_W-1:0]         step_gain,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	output logic                      done,
	output logic signed [COORD_W-1:0] read_value,
	output logic                      pair_moved,
	output logic [DIST_W-1:0]         embed_distance,
	output logic [DIST_W-1:0]         orig_distance
);

	pepu_cmd_t  cmd;
	pepu_stat_t stat;

	assign cfg_ready = 1'b1;

	pepu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	pepu_dpath #(
		.POINT_COUNT     (POINT_COUNT),
		.MAX_INPUT_DIMS  (MAX_INPUT_DIMS),
		.MAX_OUTPUT_DIMS (MAX_OUTPUT_DIMS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.action         (action),
		.first_point    (first_point),
		.second_point   (second_point),
		.dim_index      (dim_index),
		.write_value    (write_value),
		.step_gain      (step_gain),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.read_value     (read_value),
		.pair_moved     (pair_moved),
		.embed_distance (embed_distance),
		.orig_distance  (orig_distance)
	);

`ifndef SYNTHESIS
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe outside a request");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request accepted but not started");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("not idle after result");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_a, cmd.wr_b, cmd.sqrt_start, cmd.div_start}))
		else $error("conflicting datapath commands");
`endif

endmodule

>>> verif/tb_proximity_embedding_pair_update.sv
// Self-checking testbench for proximity_embedding_pair_update: coordinate writes, reads
// and pair updates against a scoreboard class that predicts every result.
// Depends on pepu_pkg and the proximity_embedding_pair_update RTL.
module tb_proximity_embedding_pair_update;
	import pepu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS   = 256;
	localparam int NIN    = 16;
	localparam int NOUT   = 4;
	localparam int WDOG   = 5000;

	typedef struct {
		action_t           act;
		logic [PT_W-1:0]   pa;
		logic [PT_W-1:0]   pb;
		logic [DIM_W-1:0]  dim;
		logic [31:0]       val;
		logic [GAIN_W-1:0] gain;
	} request_t;

	typedef struct {
		logic [31:0]       rd;
		logic              moved;
		logic [DIST_W-1:0] emb;
		logic [DIST_W-1:0] orig;
	} result_t;

	class embed_scoreboard;
		logic signed [31:0] orig_mem[NPTS*NIN];
		logic signed [31:0] emb_mem[NPTS*NOUT];
		logic [DIST_W-1:0] cut;
		int unsigned nin;
		int unsigned nout;
		result_t pending[$];
		int errors;

		function new();
			cut = '1;
			nin = 2;
			nout = 2;
			errors = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_CUT: cut = d;
				REG_IN_DIMS: nin = d[4:0];
				REG_OUT_DIMS: nout = d[2:0];
				default: ;
			endcase
		endfunction

		function int unsigned used_in();
			return (nin < 1) ? 1 : (nin > NIN) ? NIN : nin;
		endfunction

		function int unsigned used_out();
			return (nout < 1) ? 1 : (nout > NOUT) ? NOUT : nout;
		endfunction

		function logic [63:0] root64(logic [63:0] v);
			logic [63:0] r;
			logic [63:0] b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		// sum of squares saturates at 2^64-1 before the root
		function logic [DIST_W-1:0] span(bit orig_space, int a, int b, int unsigned dims);
			logic [63:0] acc;
			logic [63:0] m;
			logic [63:0] sq;
			longint d;
			acc = 0;
			for (int k = 0; k < dims; k++) begin
				if (orig_space)
					d = longint'(orig_mem[a*NIN+k]) - longint'(orig_mem[b*NIN+k]);
				else
					d = longint'(emb_mem[a*NOUT+k]) - longint'(emb_mem[b*NOUT+k]);
				m = (d < 0) ? -d : d;
				sq = m * m;
				if (acc > ~64'd0 - sq)
					acc = ~64'd0;
				else
					acc += sq;
			end
			acc = root64(acc);
			return (acc > 64'h7FFFFFFF) ? 31'h7FFFFFFF : acc[30:0];
		endfunction

		function logic signed [31:0] clip_add(logic signed [31:0] x, longint d);
			longint s;
			s = longint'(x) + d;
			if (s > 64'sh7FFFFFFF)
				return 32'h7FFFFFFF;
			if (s < -64'sh80000000)
				return 32'h80000000;
			return s[31:0];
		endfunction

		function void note_request(request_t r);
			result_t e;
			int a;
			int b;
			longint num;
			logic [63:0] nmag;
			logic [63:0] t;
			logic [63:0] dm;
			logic [63:0] m;
			longint d;
			longint mv;
			logic signed [31:0] xa;
			logic signed [31:0] xb;
			logic signed [31:0] na;
			logic signed [31:0] nb;
			bit neg;
			e = '{default: '0};
			a = r.pa;
			b = r.pb;
			case (r.act)
				ACT_WR_ORIG: orig_mem[a*NIN+r.dim] = r.val;
				ACT_WR_EMB: if (r.dim < NOUT) emb_mem[a*NOUT+r.dim] = r.val;
				ACT_RD_EMB: if (r.dim < NOUT) e.rd = emb_mem[a*NOUT+r.dim];
				default: begin
					e.emb = span(0, a, b, used_out());
					e.orig = span(1, a, b, used_in());
					if (!(e.orig > cut && e.emb >= e.orig)) begin
						num = longint'(e.orig) - longint'(e.emb);
						nmag = (num < 0) ? -num : num;
						t = ((64'(r.gain) * nmag) << 15) / (64'(e.emb) + 64'd1);
						for (int k = 0; k < used_out(); k++) begin
							xa = emb_mem[a*NOUT+k];
							xb = emb_mem[b*NOUT+k];
							d = longint'(xa) - longint'(xb);
							neg = (d < 0) != (num < 0);
							dm = (d < 0) ? -d : d;
							m = (t >> 32) * dm + (((t & 64'hFFFFFFFF) * dm) >> 32);
							if (m > (64'd1 << 33))
								m = 64'd1 << 33;
							mv = neg ? -longint'(m) : longint'(m);
							na = clip_add(xa, mv);
							nb = clip_add(xb, -mv);
							if (na != xa || nb != xb)
								e.moved = 1'b1;
							emb_mem[a*NOUT+k] = na;
							emb_mem[b*NOUT+k] = nb;
						end
					end
				end
			endcase
			pending.push_back(e);
		endfunction

		function void check_result(result_t got);
			result_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result with nothing outstanding: rd=%h moved=%b emb=%h orig=%h",
						got.rd, got.moved, got.emb, got.orig);
				return;
			end
			e = pending.pop_front();
			if (got.rd !== e.rd || got.moved !== e.moved || got.emb !== e.emb
					|| got.orig !== e.orig) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp rd=%h moved=%b emb=%h orig=%h, got rd=%h moved=%b emb=%h orig=%h",
						e.rd, e.moved, e.emb, e.orig, got.rd, got.moved, got.emb, got.orig);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [ACT_W-1:0] action;
	logic [PT_W-1:0] first_point;
	logic [PT_W-1:0] second_point;
	logic [DIM_W-1:0] dim_index;
	logic signed [COORD_W-1:0] write_value;
	logic [GAIN_W-1:0] step_gain;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic done;
	logic signed [COORD_W-1:0] read_value;
	logic pair_moved;
	logic [DIST_W-1:0] embed_distance;
	logic [DIST_W-1:0] orig_distance;

	proximity_embedding_pair_update DUT (.*);

	embed_scoreboard sb;
	bit orig_set[NPTS*NIN];
	bit emb_set[NPTS*NOUT];
	int burst_left;
	int idle_cycles;
	logic [PT_W-1:0] pool[$] = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32,
		8'd64, 8'd128, 8'd170, 8'd85};

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// results cannot be held off: take every strobe; watchdog counts quiet cycles
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result('{read_value, pair_moved, embed_distance, orig_distance});
			if (done || (start && !busy) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WDOG) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic send(request_t r);
		if (burst_left == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		action = r.act;
		first_point = r.pa;
		second_point = r.pb;
		dim_index = r.dim;
		write_value = r.val;
		step_gain = r.gain;
		start = 1'b1;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
			@(negedge clk);
		end
		sb.note_request(r);
		if (r.act == ACT_WR_ORIG)
			orig_set[r.pa*NIN+r.dim] = 1'b1;
		if (r.act == ACT_WR_EMB && r.dim < NOUT)
			emb_set[r.pa*NOUT+r.dim] = 1'b1;
		@(negedge clk);
	endtask

	task automatic req(action_t act, int pa, int pb, int dim, logic [31:0] val, int gain);
		request_t r;
		r = '{act, pa[7:0], pb[7:0], dim[3:0], val, gain[16:0]};
		send(r);
	endtask

	task automatic drain();
		start = 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
		cfg_index = idx;
		cfg_data = d;
		cfg_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		sb.set_reg(idx, d);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [31:0] coord();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			2, 3: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
			default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
		endcase
	endfunction

	function automatic bit pair_ready(int a, int b);
		for (int k = 0; k < sb.used_in(); k++)
			if (!orig_set[a*NIN+k] || !orig_set[b*NIN+k])
				return 0;
		for (int k = 0; k < sb.used_out(); k++)
			if (!emb_set[a*NOUT+k] || !emb_set[b*NOUT+k])
				return 0;
		return 1;
	endfunction

	function automatic int pick_point(bit anywhere);
		return anywhere ? $urandom_range(0, NPTS-1) : pool[$urandom_range(0, pool.size()-1)];
	endfunction

	task automatic random_item();
		int a;
		int b;
		int sel;
		int dim;
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			a = pick_point($urandom_range(0, 3) == 0);
			b = pick_point($urandom_range(0, 3) == 0);
			if (!pair_ready(a, b)) begin
				a = pick_point(0);
				b = pick_point(0);
			end
			req(ACT_PAIR, a, b, $urandom_range(0, 15), $urandom(), $urandom_range(0, 131071));
		end else if (sel < 65) begin
			req(ACT_WR_EMB, pick_point($urandom_range(0, 4) == 0), $urandom_range(0, 255),
				$urandom_range(0, 15), coord(), $urandom_range(0, 131071));
		end else if (sel < 80) begin
			req(ACT_WR_ORIG, pick_point($urandom_range(0, 4) == 0), $urandom_range(0, 255),
				$urandom_range(0, 15), coord(), $urandom_range(0, 131071));
		end else begin
			a = pick_point($urandom_range(0, 3) == 0);
			dim = $urandom_range(0, 15);
			// never read an embedding word that was not written
			if (dim < NOUT && !emb_set[a*NOUT+dim])
				a = pick_point(0);
			req(ACT_RD_EMB, a, $urandom_range(0, 255), dim, $urandom(), $urandom_range(0, 131071));
		end
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] cuts[5];
		logic [CFG_DATA_W-1:0] ins[5];
		logic [CFG_DATA_W-1:0] outs[5];
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		action = '0;
		first_point = '0;
		second_point = '0;
		dim_index = '0;
		write_value = '0;
		step_gain = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		burst_left = 0;
		idle_cycles = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// fill every coordinate of the pool so pair updates never touch unwritten words
		foreach (pool[i]) begin
			for (int k = 0; k < NIN; k++)
				req(ACT_WR_ORIG, pool[i], $urandom_range(0, 255), k, coord(), $urandom_range(0, 131071));
			for (int k = 0; k < NOUT; k++)
				req(ACT_WR_EMB, pool[i], $urandom_range(0, 255), k, coord(), $urandom_range(0, 131071));
		end

		// directed: reset settings, extremes, ignored dims, same point, zero and full gain
		req(ACT_RD_EMB, 0, 255, 0, 32'hFFFFFFFF, 131071);
		req(ACT_RD_EMB, 7, 0, 9, 0, 0);
		req(ACT_RD_EMB, 255, 255, 15, 0, 0);
		req(ACT_WR_EMB, 255, 0, 9, 32'h12345678, 0);
		req(ACT_WR_EMB, 255, 0, 0, 32'h7FFFFFFF, 0);
		req(ACT_WR_EMB, 0, 0, 0, 32'h80000000, 0);
		req(ACT_WR_ORIG, 255, 0, 15, 32'h7FFFFFFF, 0);
		req(ACT_WR_ORIG, 0, 0, 15, 32'h80000000, 0);
		req(ACT_PAIR, 255, 0, 0, 0, 131071);
		req(ACT_PAIR, 0, 255, 15, 32'hFFFFFFFF, 0);
		req(ACT_PAIR, 85, 85, 0, 0, 131071);
		req(ACT_PAIR, 170, 85, 0, 0, 65536);
		req(ACT_RD_EMB, 255, 0, 0, 0, 0);
		req(ACT_RD_EMB, 0, 0, 1, 0, 0);
		req(ACT_WR_EMB, 255, 0, 0, 32'h00010000, 0);
		req(ACT_WR_EMB, 0, 0, 0, 32'hFFFF0000, 0);
		req(ACT_PAIR, 0, 255, 0, 0, 1);
		drain();

		cuts = '{31'h7FFFFFFF, 31'd0, 31'h7FFFFFFF, 31'h00040000, 31'h00200000};
		ins  = '{31'd16, 31'd1, 31'd0, 31'd31, 31'd5};
		outs = '{31'd4, 31'd1, 31'd0, 31'd7, 31'd3};
		for (int p = 0; p < 5; p++) begin
			write_reg(REG_CUT, cuts[p]);
			write_reg(REG_IN_DIMS, ins[p]);
			write_reg(REG_OUT_DIMS, outs[p]);
			req(ACT_PAIR, 0, 255, 0, 0, 131071);
			req(ACT_PAIR, 1, 128, 0, 0, 32768);
			for (int i = 0; i < 115; i++)
				random_item();
			drain();
		end

		repeat (300) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
